// ===== rtl/ces_pkg.sv =====
// Package for the constrained endpoint snap unit: default widths, config codes.
// Depends on nothing; used by all rtl modules.
`default_nettype none
package ces_pkg;
   localparam int COORD_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF   = 8;
   localparam logic MODE_BOX  = 1'b0;
   localparam logic MODE_LINE = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/ces_sqrt.sv =====
// Pipelined restoring square root, one result bit per stage.
// Depends on ces_pkg; carries a side payload along with each operand.
`default_nettype none
module ces_sqrt #(
   parameter int IN_W  = 52,
   parameter int PAY_W = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [IN_W-1:0]      in_radicand,
   input  wire logic [PAY_W-1:0]     in_payload,
   output logic                      out_valid,
   output logic [(IN_W+1)/2-1:0]     out_root,
   output logic [PAY_W-1:0]          out_payload
);
   import ces_pkg::*;
   localparam int RW = (IN_W + 1) / 2;
   localparam int NW = 2 * RW;

   logic [RW:0]       valid_ff;
   logic [NW-1:0]     rad_ff  [RW+1];
   logic [RW+1:0]     rem_ff  [RW+1];
   logic [RW-1:0]     root_ff [RW+1];
   logic [PAY_W-1:0]  pay_ff  [RW+1];

   // stage 0 holds the padded operand
   always_ff @(posedge clock) begin
      if (reset) valid_ff[0] <= 1'b0;
      else valid_ff[0] <= in_valid;
      rad_ff[0]  <= NW'(in_radicand);
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      pay_ff[0]  <= in_payload;
   end

   // bring in two operand bits per stage, subtract the trial value when it fits
   for (genvar s = 0; s < RW; s++) begin : g_stage
      logic [RW+1:0]   rem_sh_in;
      logic [RW+1:0]   trial_in;
      logic            take_in;
      always_comb begin
         rem_sh_in = {rem_ff[s][RW-1:0], rad_ff[s][NW-1:NW-2]};
         trial_in  = {root_ff[s], 2'b01};
         take_in   = rem_sh_in >= trial_in;
      end
      always_ff @(posedge clock) begin
         if (reset) valid_ff[s+1] <= 1'b0;
         else valid_ff[s+1] <= valid_ff[s];
         rad_ff[s+1]  <= rad_ff[s] << 2;
         rem_ff[s+1]  <= take_in ? rem_sh_in - trial_in : rem_sh_in;
         root_ff[s+1] <= {root_ff[s][RW-2:0], take_in};
         pay_ff[s+1]  <= pay_ff[s];
      end
   end

   assign out_valid   = valid_ff[RW];
   assign out_root    = root_ff[RW];
   assign out_payload = pay_ff[RW];
endmodule
`default_nettype wire

// ===== rtl/constrained_endpoint_snap_unit.sv =====
// Top level of the constrained endpoint snap unit.
// Depends on ces_pkg and ces_sqrt.
`default_nettype none
// Usage: drive req_* with start high for one cycle per point; busy is always
// low, so a point may enter every cycle. Each result appears on rsp_out_x and
// rsp_out_y for one cycle with rsp_strobe high, in input order; the receiver
// cannot stall. The pipeline holds three front stages (offset, squares, octant
// decision), an operand stage and one stage per root bit in the square root
// unit, and one output stage: COORD_WIDTH + 7 register stages (31 at the
// default width of 24).
// Throughput is one point per cycle, set by the fully pipelined root unit.
// Pass-through and box mode ride the same pipeline with the same latency.
// The csr channel writes constrain_mode (reset 1 = line snap, 0 = box); it is
// always ready and should only be written while no point is in flight.
// Synchronous reset clears all valid bits and sets constrain_mode to line.
module constrained_endpoint_snap_unit #(
   parameter int COORD_WIDTH = ces_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = ces_pkg::FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [COORD_WIDTH-1:0] req_point_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_point_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_anchor_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_anchor_y,
   input  wire logic                          req_anchor_present,
   input  wire logic                          req_constrain_on,
   output logic                               rsp_strobe,
   output logic signed [COORD_WIDTH-1:0]      rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_out_y,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic                          csr_constrain_mode
);
   import ces_pkg::*;
   localparam int W   = COORD_WIDTH;
   localparam int DW  = W + 1;          // offset width
   localparam int SQW = 2 * DW + 2;     // 4*S width
   localparam int RW  = (SQW + 1) / 2;  // root width
   // payload: anchor x,y; px,py pass; mode flags; signs
   localparam int PAY_W = 4 * W + 6;

   logic mode_ff;
   logic unused_frac;
   assign unused_frac = (FRAC_BITS < 0);

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // hold the mode register
   always_ff @(posedge clock) begin
      if (reset) mode_ff <= MODE_LINE;
      else if (csr_valid && csr_ready) mode_ff <= csr_constrain_mode;
   end

   // stage 1: offsets and magnitudes
   logic              v1_ff, pass1_ff, mode1_ff, sx1_ff, sy1_ff;
   logic [DW-1:0]     ax1_ff, ay1_ff;
   logic signed [W-1:0] px1_ff, py1_ff, qx1_ff, qy1_ff;
   logic signed [DW-1:0] dx_in, dy_in;
   always_comb begin
      dx_in = DW'(req_point_x) - DW'(req_anchor_x);
      dy_in = DW'(req_point_y) - DW'(req_anchor_y);
   end
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= start && !busy;
      pass1_ff <= !(req_anchor_present && req_constrain_on);
      mode1_ff <= mode_ff;
      sx1_ff   <= dx_in[DW-1];
      sy1_ff   <= dy_in[DW-1];
      ax1_ff   <= dx_in[DW-1] ? DW'(-dx_in) : DW'(dx_in);
      ay1_ff   <= dy_in[DW-1] ? DW'(-dy_in) : DW'(dy_in);
      px1_ff   <= req_point_x;
      py1_ff   <= req_point_y;
      qx1_ff   <= req_anchor_x;
      qy1_ff   <= req_anchor_y;
   end

   // stage 2: squares and the cross product of the octant test
   logic                v2_ff, pass2_ff, mode2_ff, sx2_ff, sy2_ff, zero2_ff, axge2_ff;
   logic [2*DW-1:0]     xx2_ff, yy2_ff, xy2_ff;
   logic [DW-1:0]       big2_ff;
   logic signed [W-1:0] px2_ff, py2_ff, qx2_ff, qy2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      pass2_ff <= pass1_ff;
      mode2_ff <= mode1_ff;
      sx2_ff   <= sx1_ff;
      sy2_ff   <= sy1_ff;
      zero2_ff <= (ax1_ff == '0) && (ay1_ff == '0);
      axge2_ff <= ax1_ff >= ay1_ff;
      big2_ff  <= (ax1_ff >= ay1_ff) ? ax1_ff : ay1_ff;
      xx2_ff   <= (2*DW)'(ax1_ff) * (2*DW)'(ax1_ff);
      yy2_ff   <= (2*DW)'(ay1_ff) * (2*DW)'(ay1_ff);
      xy2_ff   <= (2*DW)'(ax1_ff) * (2*DW)'(ay1_ff);
      px2_ff   <= px1_ff;
      py2_ff   <= py1_ff;
      qx2_ff   <= qx1_ff;
      qy2_ff   <= qy1_ff;
   end

   // stage 3: octant choice; (ax+ay)^2 < 2ax^2 <=> ax^2 > ay^2 + 2axay
   logic            v3_ff, hor3_ff, ver3_ff;
   logic [SQW-1:0]  rad3_ff;
   logic [PAY_W-1:0] pay3_ff;
   logic [SQW-1:0]  s_in, hx_in, hy_in;
   always_comb begin
      s_in  = SQW'(xx2_ff) + SQW'(yy2_ff);
      hx_in = SQW'(yy2_ff) + (SQW'(xy2_ff) << 1);
      hy_in = SQW'(xx2_ff) + (SQW'(xy2_ff) << 1);
   end
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      hor3_ff <= SQW'(xx2_ff) > hx_in;
      ver3_ff <= SQW'(yy2_ff) > hy_in;
      rad3_ff <= (SQW'(xx2_ff) > hx_in || SQW'(yy2_ff) > hy_in) ? (s_in << 2) : (s_in << 1);
      pay3_ff <= {px2_ff, py2_ff, qx2_ff, qy2_ff, pass2_ff,
                  (mode2_ff == MODE_LINE) && !zero2_ff, sx2_ff, sy2_ff,
                  1'b0, 1'b0};
   end

   // box size rides beside the root
   logic [PAY_W+DW+1:0] rpay_in, rpay_out;
   logic [DW-1:0] big3_ff;
   logic          axge3_ff;
   always_ff @(posedge clock) begin
      big3_ff  <= big2_ff;
      axge3_ff <= axge2_ff;
   end
   assign rpay_in = {pay3_ff[PAY_W-1:2], hor3_ff, ver3_ff, big3_ff, axge3_ff, 1'b0};

   logic          vr;
   logic [RW-1:0] root;
   ces_sqrt #(.IN_W(SQW), .PAY_W(PAY_W+DW+2)) u_sqrt (
      .clock(clock), .reset(reset),
      .in_valid(v3_ff), .in_radicand(rad3_ff), .in_payload(rpay_in),
      .out_valid(vr), .out_root(root), .out_payload(rpay_out)
   );

   // final stage: apply length, add anchor, saturate
   logic signed [W-1:0] px_f, py_f, qx_f, qy_f;
   logic pass_f, line_f, sx_f, sy_f, hor_f, ver_f, unused_axge, unused_z;
   logic [DW-1:0] big_f;
   logic [RW-1:0] len_in;
   logic signed [RW+2:0] offx_in, offy_in, rx_in, ry_in;
   logic signed [W-1:0] ox_in, oy_in;
   assign {px_f, py_f, qx_f, qy_f, pass_f, line_f, sx_f, sy_f, hor_f, ver_f,
           big_f, unused_axge, unused_z} = rpay_out;

   function automatic logic signed [W-1:0] sat(input logic signed [RW+2:0] v);
      logic signed [RW+2:0] hi, lo;
      hi = (RW+3)'((64'(1) << (W-1)) - 1);
      lo = -hi - 1;
      if (v > hi) sat = W'(hi);
      else if (v < lo) sat = W'(lo);
      else sat = W'(v);
   endfunction

   always_comb begin
      len_in = RW'((root + RW'(1)) >> 1);
      if (!line_f) begin
         offx_in = sx_f ? -(RW+3)'(big_f) : (RW+3)'(big_f);
         offy_in = sy_f ? -(RW+3)'(big_f) : (RW+3)'(big_f);
      end else begin
         offx_in = ver_f ? '0 : (sx_f ? -(RW+3)'(len_in) : (RW+3)'(len_in));
         offy_in = hor_f ? '0 : (sy_f ? -(RW+3)'(len_in) : (RW+3)'(len_in));
      end
      rx_in = (RW+3)'(qx_f) + offx_in;
      ry_in = (RW+3)'(qy_f) + offy_in;
      // zero offset in line mode clears line_f and lands on anchor: big 0, signs positive
      ox_in = pass_f ? px_f : sat(rx_in);
      oy_in = pass_f ? py_f : sat(ry_in);
   end

   logic o_v_ff;
   logic signed [W-1:0] ox_ff, oy_ff;
   always_ff @(posedge clock) begin
      if (reset) o_v_ff <= 1'b0;
      else o_v_ff <= vr;
      ox_ff <= ox_in;
      oy_ff <= oy_in;
   end
   assign rsp_strobe = o_v_ff;
   assign rsp_out_x  = ox_ff;
   assign rsp_out_y  = oy_ff;

   // zero box offset (box mode, or line mode with zero offset) must return the anchor x
   a_zero_anchor: assert property (@(posedge clock) disable iff (reset)
      vr && !pass_f && line_f == 1'b0 && big_f == '0 |=> rsp_out_x == $past(qx_f))
      else $error("zero box offset missed anchor");
   a_pass: assert property (@(posedge clock) disable iff (reset)
      vr && pass_f |=> rsp_strobe && rsp_out_x == $past(px_f) && rsp_out_y == $past(py_f))
      else $error("pass-through altered point");
   a_axis: assert property (@(posedge clock) disable iff (reset)
      vr && !(hor_f && ver_f) || !vr)
      else $error("octant both axes");
   a_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");
endmodule
`default_nettype wire
